### hw/rtl/erd_pkg.sv
`default_nettype none

package erd_pkg;

	// Fixed widths of the request and result fields
	localparam int REQ_W      = 2;
	localparam int REC_PORT_W = 64;

	// Parameter defaults
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int RECORD_BITS_DEF = 64;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_TAIL = 2'd0,
		REQ_PUSH_HEAD = 2'd1,
		REQ_POP       = 2'd2,
		REQ_CLEAR     = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DROPPED = 2'd1,
		ST_REFUSED = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// Result control passed from the pointer logic to the output side
	typedef struct packed {
		logic    valid;
		logic    pop;
		status_t status;
	} res_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/event_ring_deque_drop_oldest.sv
`default_nettype none

// Ring deque of QUEUE_DEPTH event records. Issue a request by raising start
// with req_type and record_in; busy never rises, so a request is taken in
// every cycle. Each request yields one result, shown for exactly one cycle
// with done high, in the cycle after the request was taken: the record
// memory has a single synchronous read port, and a pop's read overlaps the
// next request's pointer update. The receiver cannot stall the result, so
// capture it when done is high. A tail push on a full queue overwrites the
// oldest record (status dropped); a head push on a full queue is refused; a
// pop on an empty queue reports empty with record_out zero.
// Clear takes effect at once and needs no sweep of the memory.
module event_ring_deque_drop_oldest
	import erd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int RECORD_BITS = RECORD_BITS_DEF,
	parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [REQ_W-1:0]      req_type,
	input  wire logic [REC_PORT_W-1:0] record_in,
	output logic                       done,
	output logic      [1:0]            status,
	output logic      [REC_PORT_W-1:0] record_out,
	output logic      [CW-1:0]         fill_count
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic                   accept;
	logic                   mem_we, mem_re;
	logic [AW-1:0]          mem_waddr, mem_raddr;
	logic [RECORD_BITS-1:0] mem_wdata, mem_rdata;
	res_ctl_t               res_s1;
	logic [CW-1:0]          count_s1;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	erd_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.RECORD_BITS (RECORD_BITS),
		.AW          (AW),
		.CW          (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_type  (req_type),
		.record_in (record_in),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.res_s1    (res_s1),
		.count_s1  (count_s1)
	);

	erd_ram #(
		.WIDTH (RECORD_BITS),
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Drive the result; zero the record unless this was a successful pop
	assign done       = res_s1.valid;
	assign status     = res_s1.status;
	assign fill_count = count_s1;
	assign record_out = res_s1.pop ? REC_PORT_W'(mem_rdata) : '0;

endmodule

`default_nettype wire

### hw/rtl/erd_ram.sv
`default_nettype none

module erd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/erd_ctrl.sv
`default_nettype none

module erd_ctrl
	import erd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int RECORD_BITS = RECORD_BITS_DEF,
	parameter int AW          = $clog2(QUEUE_DEPTH),
	parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire logic [REQ_W-1:0]       req_type,
	input  wire logic [REC_PORT_W-1:0]  record_in,
	output logic                        mem_we,
	output logic      [AW-1:0]          mem_waddr,
	output logic      [RECORD_BITS-1:0] mem_wdata,
	output logic                        mem_re,
	output logic      [AW-1:0]          mem_raddr,
	output res_ctl_t                    res_s1,
	output logic      [CW-1:0]          count_s1
);

	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;

	logic [AW-1:0] head_d, tail_d;
	logic [CW-1:0] count_d;
	status_t       status_d;
	logic          pop_d;
	logic          full, empty;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
		return (i == '0) ? LAST_IDX : i - AW'(1);
	endfunction

	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign mem_wdata = record_in[RECORD_BITS-1:0];
	assign mem_raddr = head_q;

	// Decode the request into pointer updates and at most one memory access
	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		status_d  = ST_OK;
		pop_d     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_re    = 1'b0;
		case (req_type_t'(req_type))
			REQ_PUSH_TAIL: begin
				mem_we = accept;
				tail_d = ring_next(tail_q);
				if (full) begin
					head_d   = ring_next(head_q);
					status_d = ST_DROPPED;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			REQ_PUSH_HEAD: begin
				if (full) begin
					status_d = ST_REFUSED;
				end else begin
					head_d    = ring_prev(head_q);
					mem_we    = accept;
					mem_waddr = ring_prev(head_q);
					count_d   = count_q + CW'(1);
				end
			end
			REQ_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					mem_re  = accept;
					pop_d   = 1'b1;
					head_d  = ring_next(head_q);
					count_d = count_q - CW'(1);
				end
			end
			REQ_CLEAR: begin
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Hold pointers and count; advance them on an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	// Register the result control alongside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= '0;
		end else begin
			res_s1.valid  <= accept;
			res_s1.pop    <= accept & pop_d;
			res_s1.status <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_s1 <= count_d;
		end
	end

endmodule

`default_nettype wire
